FILE: rtl/core/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared constants and helper functions of the convolution and sigmoid
// layer: field widths, item kinds, register indexes and the sigmoid table.
// ----------------------------------------------------------------------------
`default_nettype none

package c2s_pkg;

  // Default sizes of the layer.
  localparam int unsigned FILTERS_DEF    = 5;
  localparam int unsigned TAP_SIZE_DEF   = 5;
  localparam int unsigned MAX_ROWS_DEF   = 32;
  localparam int unsigned MAX_COLS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 16;

  // Fixed field widths of the ports.
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned FSEL_W     = 3;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned ACT_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BIAS   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FILTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 2'd2;

  // Register reset values and the smallest image size.
  localparam int unsigned RST_FILTERS = 5;
  localparam int unsigned RST_ROWS    = 28;
  localparam int unsigned RST_COLS    = 28;
  localparam int unsigned MIN_SIZE    = 5;

  // Sigmoid table: 129 entries, steps of 1/16, decay factor e^-1/16 in Q0.32.
  localparam int unsigned SIG_ENTRIES = 129;
  localparam int unsigned SIG_IDX_W   = 8;
  localparam logic [63:0] SIG_K       = 64'd4034748382;

  // Saturates a value into the range lo..hi.
  function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
    int unsigned r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  // One sigmoid table entry, evaluated while the design elaborates.
  // The exponential is repeated multiplication, the reciprocal a long division.
  function automatic logic [ACT_W-1:0] sig_entry(input int unsigned idx);
    logic [95:0] e;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    e = 96'd1 << 32;
    for (int unsigned i = 0; i < idx; i++) begin
      e = (e * {32'd0, SIG_K} + (96'd1 << 31)) >> 32;
    end
    d   = e[63:0] + (64'd1 << 32);
    num = (64'd1 << 48) + (d >> 1);
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[b] = 1'b1;
      end
    end
    return quo[ACT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/c2s_ram.sv
// ----------------------------------------------------------------------------
// c2s_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/conv2d_sigmoid_layer.sv
// ----------------------------------------------------------------------------
// conv2d_sigmoid_layer
// Streaming 2-D convolution with zero padding, per-position bias and a table
// sigmoid, for up to FILTERS filters of TAP_SIZE x TAP_SIZE taps.
// ----------------------------------------------------------------------------
// Usage: weights (kind 0) and biases (kind 1) are loaded as input items, then
// image pixels (kind 2) follow in raster order. Each pixel item releases the
// results whose window it completes, row by row, column by column, filter
// ascending; the last pixel of a row or of the image flushes the edge results.
// The result item flagged last closes the results of one input item, and
// frame_end marks the final result of the image.
// For every result item the window is read one tap per cycle from the line
// and weight memories and multiplied in a single multiplier, and the result
// then waits through any output stall. One item is worked on at a time;
// in_ready_o is low meanwhile.
// Configuration writes are taken when the block is idle, ahead of a waiting
// input item; a size write restarts the frame. Reset clears the position
// counters and restores the register defaults; the memories hold their
// contents until written.
// A stalled receiver holds the result register and the whole block.
// ----------------------------------------------------------------------------
`default_nettype none

module conv2d_sigmoid_layer #(
  parameter int unsigned FILTERS    = c2s_pkg::FILTERS_DEF,
  parameter int unsigned TAP_SIZE   = c2s_pkg::TAP_SIZE_DEF,
  parameter int unsigned MAX_ROWS   = c2s_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS   = c2s_pkg::MAX_COLS_DEF,
  parameter int unsigned VALUE_BITS = c2s_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration channel.
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [c2s_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [c2s_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input channel.
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [c2s_pkg::KIND_W-1:0]       kind_i,
  input  wire logic [c2s_pkg::FSEL_W-1:0]       filter_sel_i,
  input  wire logic [c2s_pkg::POS_W-1:0]        row_sel_i,
  input  wire logic [c2s_pkg::POS_W-1:0]        col_sel_i,
  input  wire logic signed [VALUE_BITS-1:0]     value_i,
  // Output channel.
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [c2s_pkg::FSEL_W-1:0]       filter_out_o,
  output logic      [c2s_pkg::POS_W-1:0]        out_row_o,
  output logic      [c2s_pkg::POS_W-1:0]        out_col_o,
  output logic      [c2s_pkg::ACT_W-1:0]        activation_o,
  output logic                                  last_o,
  output logic                                  frame_end_o
);

  import c2s_pkg::*;

  localparam int unsigned HALF   = (TAP_SIZE - 1) / 2;
  localparam int unsigned LAG    = TAP_SIZE - 1 - HALF;
  localparam int unsigned FRAC   = VALUE_BITS - 3;
  localparam int unsigned MAXDIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned CNT_W  = $clog2(MAXDIM + 1);
  localparam int unsigned PW     = CNT_W + 2;
  localparam int unsigned KW     = $clog2(TAP_SIZE);
  localparam int unsigned W_DEP  = FILTERS * TAP_SIZE * TAP_SIZE;
  localparam int unsigned B_DEP  = FILTERS * MAX_ROWS * MAX_COLS;
  localparam int unsigned L_DEP  = TAP_SIZE * MAX_COLS;
  localparam int unsigned WA_W   = $clog2(W_DEP);
  localparam int unsigned BA_W   = $clog2(B_DEP);
  localparam int unsigned LA_W   = $clog2(L_DEP);
  localparam int unsigned PROD_W = 2 * VALUE_BITS;
  localparam int unsigned ACC_W  = 2 * VALUE_BITS + 6;
  localparam int unsigned SIG_SH = 2 * FRAC - 4;

  localparam logic [ACC_W-1:0] SIG_LIM = ACC_W'(1) << (2 * FRAC + 3);
  localparam logic [ACC_W-1:0] SIG_RND = ACC_W'(1) << (2 * FRAC - 5);

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_TAP, ST_DRAIN, ST_SIG, ST_LUT, ST_OUT
  } state_e;

  state_e                  state_q;
  logic [FSEL_W-1:0]       fiu_q;
  logic [CNT_W-1:0]        rows_q, cols_q;
  logic [CNT_W-1:0]        pix_r_q, pix_c_q;
  logic [KW-1:0]           pslot_q;
  logic signed [PW-1:0]    wr_q, cur_r_q, cur_c_q, rhi_q, chi_q, cstart_q;
  logic [KW-1:0]           wslot_q, tk_q, tl_q;
  logic [FSEL_W-1:0]       fk_q;
  logic                    fdone_q, drain_q;
  logic                    s1_v_q, s2_v_q, bias_v_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    sig_neg_q, sig_sat_q;
  logic [SIG_IDX_W-1:0]    sig_idx_q;
  logic [FSEL_W-1:0]       o_f_q;
  logic [POS_W-1:0]        o_r_q, o_c_q;
  logic [ACT_W-1:0]        o_act_q;
  logic                    o_last_q, o_fend_q;

  logic [ACT_W-1:0] sig_rom [SIG_ENTRIES];

  // Sigmoid table, constant after elaboration.
  for (genvar gi = 0; gi < SIG_ENTRIES; gi++) begin : g_sig
    assign sig_rom[gi] = sig_entry(gi);
  end

  // A waiting configuration write goes ahead of a waiting input item.
  logic in_fire, cfg_fire;
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Load checks and write addresses.
  logic            w_ok, b_ok;
  logic [WA_W-1:0] w_waddr;
  logic [BA_W-1:0] b_waddr;
  logic [LA_W-1:0] l_waddr;
  assign w_ok = (int'(filter_sel_i) < FILTERS) && (int'(row_sel_i) < TAP_SIZE) &&
                (int'(col_sel_i) < TAP_SIZE);
  assign b_ok = (int'(filter_sel_i) < FILTERS) && (int'(row_sel_i) < MAX_ROWS) &&
                (int'(col_sel_i) < MAX_COLS);
  assign w_waddr = WA_W'((int'(filter_sel_i) * TAP_SIZE + int'(row_sel_i)) * TAP_SIZE +
                         int'(col_sel_i));
  assign b_waddr = BA_W'((int'(filter_sel_i) * MAX_ROWS + int'(row_sel_i)) * MAX_COLS +
                         int'(col_sel_i));
  assign l_waddr = LA_W'(int'(pslot_q) * MAX_COLS + int'(pix_c_q));

  // Range of results released by the current pixel.
  logic signed [PW-1:0] pr_s, pc_s, rlo, clo, rhi, chi;
  logic                 row_end, col_end, has_out;
  assign pr_s    = PW'(pix_r_q);
  assign pc_s    = PW'(pix_c_q);
  assign row_end = (pix_r_q == rows_q - CNT_W'(1));
  assign col_end = (pix_c_q == cols_q - CNT_W'(1));
  assign rlo     = pr_s - PW'(LAG);
  assign clo     = pc_s - PW'(LAG);
  assign rhi     = row_end ? pr_s : rlo;
  assign chi     = col_end ? pc_s : clo;
  assign has_out = !rhi[PW-1] && !chi[PW-1];

  // Tap position, padding test and line slot.
  logic signed [PW-1:0] ty, tx, rows_s, cols_s;
  logic                 tap_in;
  logic [KW-1:0]        tdiff, tslot;
  assign rows_s = PW'(rows_q);
  assign cols_s = PW'(cols_q);
  assign ty     = cur_r_q - PW'(HALF) + PW'(tk_q);
  assign tx     = cur_c_q - PW'(HALF) + PW'(tl_q);
  assign tap_in = !ty[PW-1] && (ty < rows_s) && !tx[PW-1] && (tx < cols_s);
  assign tdiff  = KW'(wr_q - ty);
  assign tslot  = (wslot_q >= tdiff) ? wslot_q - tdiff : wslot_q + KW'(TAP_SIZE) - tdiff;

  // Memory ports.
  logic            l_re, w_re, b_re;
  logic [LA_W-1:0] l_raddr;
  logic [WA_W-1:0] w_raddr;
  logic [BA_W-1:0] b_raddr;
  logic signed [VALUE_BITS-1:0] l_rdata, w_rdata, b_rdata;
  assign l_re    = (state_q == ST_TAP) && tap_in;
  assign w_re    = l_re;
  assign b_re    = (state_q == ST_INIT);
  assign l_raddr = LA_W'(int'(tslot) * MAX_COLS + int'(tx[CNT_W-1:0]));
  assign w_raddr = WA_W'((int'(fk_q) * TAP_SIZE + int'(tk_q)) * TAP_SIZE + int'(tl_q));
  assign b_raddr = BA_W'((int'(fk_q) * MAX_ROWS + int'(cur_r_q[CNT_W-1:0])) * MAX_COLS +
                         int'(cur_c_q[CNT_W-1:0]));

  c2s_ram #(.WIDTH(VALUE_BITS), .DEPTH(W_DEP)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (kind_i == KIND_WEIGHT) && w_ok),
    .waddr_i (w_waddr),
    .wdata_i (value_i),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  c2s_ram #(.WIDTH(VALUE_BITS), .DEPTH(B_DEP)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (kind_i == KIND_BIAS) && b_ok),
    .waddr_i (b_waddr),
    .wdata_i (value_i),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  c2s_ram #(.WIDTH(VALUE_BITS), .DEPTH(L_DEP)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (kind_i == KIND_PIXEL)),
    .waddr_i (l_waddr),
    .wdata_i (value_i),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  // Sigmoid input: magnitude, saturation and table index.
  logic [ACC_W-1:0] mag, idx_full;
  logic             acc_neg;
  assign acc_neg  = acc_q[ACC_W-1];
  assign mag      = acc_neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign idx_full = (mag + SIG_RND) >> SIG_SH;

  // Table output and the final activation.
  logic [ACT_W:0] act_full;
  logic [ACT_W-1:0] tval;
  assign tval = sig_rom[sig_idx_q];
  always_comb begin
    if (sig_sat_q) begin
      act_full = sig_neg_q ? '0 : (ACT_W+1)'({ACT_W{1'b1}});
    end else if (sig_neg_q) begin
      act_full = ((ACT_W+1)'(1) << ACT_W) - (ACT_W+1)'(tval);
    end else begin
      act_full = (ACT_W+1)'(tval);
    end
  end

  logic res_last;
  assign res_last = (cur_r_q == rhi_q) && (cur_c_q == chi_q) &&
                    (fk_q == fiu_q - FSEL_W'(1));

  // Tap pipeline: read, multiply, accumulate.
  always_ff @(posedge clk_i) begin
    prod_q <= l_rdata * w_rdata;
    if (bias_v_q) begin
      acc_q <= ACC_W'(b_rdata) <<< FRAC;
    end else if (s2_v_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Sequencer, counters, registers and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fiu_q     <= FSEL_W'(clamp_u(RST_FILTERS, 1, FILTERS));
      rows_q    <= CNT_W'(clamp_u(RST_ROWS, MIN_SIZE, MAX_ROWS));
      cols_q    <= CNT_W'(clamp_u(RST_COLS, MIN_SIZE, MAX_COLS));
      pix_r_q   <= '0;
      pix_c_q   <= '0;
      pslot_q   <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      bias_v_q  <= 1'b0;
      drain_q   <= 1'b0;
      wr_q      <= '0;
      wslot_q   <= '0;
      cur_r_q   <= '0;
      cur_c_q   <= '0;
      rhi_q     <= '0;
      chi_q     <= '0;
      cstart_q  <= '0;
      fk_q      <= '0;
      tk_q      <= '0;
      tl_q      <= '0;
      fdone_q   <= 1'b0;
      sig_neg_q <= 1'b0;
      sig_sat_q <= 1'b0;
      sig_idx_q <= '0;
      o_f_q     <= '0;
      o_r_q     <= '0;
      o_c_q     <= '0;
      o_act_q   <= '0;
      o_last_q  <= 1'b0;
      o_fend_q  <= 1'b0;
    end else begin
      s1_v_q   <= l_re;
      s2_v_q   <= s1_v_q;
      bias_v_q <= b_re;

      // Register writes; a size write restarts the frame.
      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_FILTERS: fiu_q <= FSEL_W'(clamp_u(int'(cfg_data_i), 1, FILTERS));
          CFG_ROWS: begin
            rows_q  <= CNT_W'(clamp_u(int'(cfg_data_i), MIN_SIZE, MAX_ROWS));
            pix_r_q <= '0;
            pix_c_q <= '0;
            pslot_q <= '0;
          end
          CFG_COLS: begin
            cols_q  <= CNT_W'(clamp_u(int'(cfg_data_i), MIN_SIZE, MAX_COLS));
            pix_r_q <= '0;
            pix_c_q <= '0;
            pslot_q <= '0;
          end
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire && (kind_i == KIND_PIXEL)) begin
            // Capture the result range, then advance the pixel position.
            wr_q     <= pr_s;
            wslot_q  <= pslot_q;
            rhi_q    <= rhi;
            chi_q    <= chi;
            cur_r_q  <= rlo[PW-1] ? '0 : rlo;
            cur_c_q  <= clo[PW-1] ? '0 : clo;
            cstart_q <= clo[PW-1] ? '0 : clo;
            fk_q     <= '0;
            fdone_q  <= row_end && col_end;
            if (has_out) begin
              state_q <= ST_INIT;
            end
            if (col_end) begin
              pix_c_q <= '0;
              if (row_end) begin
                pix_r_q <= '0;
                pslot_q <= '0;
              end else begin
                pix_r_q <= pix_r_q + CNT_W'(1);
                pslot_q <= (pslot_q == KW'(TAP_SIZE - 1)) ? '0 : pslot_q + KW'(1);
              end
            end else begin
              pix_c_q <= pix_c_q + CNT_W'(1);
            end
          end
        end
        ST_INIT: begin
          tk_q    <= '0;
          tl_q    <= '0;
          state_q <= ST_TAP;
        end
        ST_TAP: begin
          if (tl_q == KW'(TAP_SIZE - 1)) begin
            tl_q <= '0;
            if (tk_q == KW'(TAP_SIZE - 1)) begin
              drain_q <= 1'b0;
              state_q <= ST_DRAIN;
            end else begin
              tk_q <= tk_q + KW'(1);
            end
          end else begin
            tl_q <= tl_q + KW'(1);
          end
        end
        ST_DRAIN: begin
          drain_q <= 1'b1;
          if (drain_q) begin
            state_q <= ST_SIG;
          end
        end
        ST_SIG: begin
          sig_neg_q <= acc_neg;
          sig_sat_q <= (mag > SIG_LIM);
          sig_idx_q <= SIG_IDX_W'(idx_full);
          state_q   <= ST_LUT;
        end
        ST_LUT: begin
          o_f_q    <= fk_q;
          o_r_q    <= cur_r_q[POS_W-1:0];
          o_c_q    <= cur_c_q[POS_W-1:0];
          o_act_q  <= act_full[ACT_W-1:0];
          o_last_q <= res_last;
          o_fend_q <= res_last && fdone_q;
          state_q  <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            if (o_last_q) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_INIT;
              if (fk_q == fiu_q - FSEL_W'(1)) begin
                fk_q <= '0;
                if (cur_c_q == chi_q) begin
                  cur_c_q <= cstart_q;
                  cur_r_q <= cur_r_q + PW'(1);
                end else begin
                  cur_c_q <= cur_c_q + PW'(1);
                end
              end else begin
                fk_q <= fk_q + FSEL_W'(1);
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = (state_q == ST_OUT);
  assign filter_out_o = o_f_q;
  assign out_row_o    = o_r_q;
  assign out_col_o    = o_c_q;
  assign activation_o = o_act_q;
  assign last_o       = o_last_q;
  assign frame_end_o  = o_fend_q;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Convolution and sigmoid layer testbench
// Loads weights and biases, then streams image frames of several sizes and
// filter counts through the layer. Every result item is checked field by field
// against an in-bench model of the window sums and the table sigmoid. Both
// channels idle at random, and one phase holds the output off for a long time.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import c2s_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int NFIL = 5;
  localparam int TAPS = 5;
  localparam int HALF = 2;
  localparam int MROWS = 32;
  localparam int MCOLS = 32;
  localparam int FRAC_BITS = 13;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [FSEL_W-1:0] fil;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [ACT_W-1:0]  act;
    logic              last;
    logic              fend;
  } act_item_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [FSEL_W-1:0] fsel;
    logic [POS_W-1:0]  rsel;
    logic [POS_W-1:0]  csel;
    logic [15:0]       val;
    bit                typed;
    logic [ACT_W-1:0]  typed_act;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [KIND_W-1:0] kind_i = '0;
  logic [FSEL_W-1:0] filter_sel_i = '0;
  logic [POS_W-1:0] row_sel_i = '0;
  logic [POS_W-1:0] col_sel_i = '0;
  logic signed [15:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [FSEL_W-1:0] filter_out_o;
  logic [POS_W-1:0] out_row_o;
  logic [POS_W-1:0] out_col_o;
  logic [ACT_W-1:0] activation_o;
  logic last_o;
  logic frame_end_o;

  conv2d_sigmoid_layer dut (.*);

  // Model state of the layer.
  int wgt_mem [NFIL][TAPS][TAPS];
  int bias_mem [NFIL][MROWS][MCOLS];
  bit bias_set [NFIL][MROWS][MCOLS];
  int line_mem [TAPS][MCOLS];
  int pix_row, pix_col;
  int cur_filters, cur_rows, cur_cols;
  logic [ACT_W-1:0] sig_tab [SIG_ENTRIES];

  act_item_t pending_acts[$];
  int n_errors = 0;
  int n_cycles = 0;
  bit hold_req = 0;
  bit rx_quiet = 0;
  bit tx_quiet = 0;

  // Clock and cycle limit.
  initial begin
    forever begin
      #4 clk_i = ~clk_i;
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Builds the sigmoid table: repeated decay by e^-1/16, then a rounded reciprocal.
  function automatic void build_sig_tab();
    longint unsigned ex, den;
    ex = 64'd1 << 32;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      den = (64'd1 << 32) + ex;
      sig_tab[i] = ACT_W'(((64'd1 << 48) + den / 2) / den);
      ex = (ex * 64'd4034748382 + (64'd1 << 31)) >> 32;
    end
  endfunction

  function automatic logic [ACT_W-1:0] sigmoid_of(longint x);
    longint unsigned mag;
    int unsigned p;
    mag = (x < 0) ? longint'(-x) : x;
    if (mag > (64'd8 << (2 * FRAC_BITS))) return (x < 0) ? '0 : 16'hFFFF;
    p = sig_tab[(mag + (64'd1 << (2 * FRAC_BITS - 5))) >> (2 * FRAC_BITS - 4)];
    return (x < 0) ? ACT_W'(65536 - p) : ACT_W'(p);
  endfunction

  // Window of one output position for one filter, zero outside the image.
  function automatic longint conv_sum(int f, int r, int c);
    longint acc;
    int y, xc;
    acc = 0;
    for (int k = 0; k < TAPS; k++) begin
      y = r - HALF + k;
      if (y < 0 || y >= cur_rows) continue;
      for (int l = 0; l < TAPS; l++) begin
        xc = c - HALF + l;
        if (xc < 0 || xc >= cur_cols) continue;
        acc += longint'(line_mem[y % TAPS][xc]) * longint'(wgt_mem[f][k][l]);
      end
    end
    return acc + longint'(bias_mem[f][r][c]) * (longint'(1) << FRAC_BITS);
  endfunction

  function automatic int clamp_reg(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Applies one accepted item to the model and queues the activations it releases.
  function automatic void predict_acts(stim_row_t it);
    int v, r_hi, c_hi, n;
    bit fdone;
    act_item_t a;
    v = int'(signed'(it.val));
    n = 0;
    if (it.kind == KIND_WEIGHT) begin
      if (it.fsel < NFIL && it.rsel < TAPS && it.csel < TAPS)
        wgt_mem[it.fsel][it.rsel][it.csel] = v;
    end else if (it.kind == KIND_BIAS) begin
      if (it.fsel < NFIL) begin
        bias_mem[it.fsel][it.rsel][it.csel] = v;
        bias_set[it.fsel][it.rsel][it.csel] = 1;
      end
    end else if (it.kind == KIND_PIXEL) begin
      line_mem[pix_row % TAPS][pix_col] = v;
      fdone = (pix_row == cur_rows - 1) && (pix_col == cur_cols - 1);
      r_hi = (pix_row == cur_rows - 1) ? cur_rows - 1 : pix_row - HALF;
      c_hi = (pix_col == cur_cols - 1) ? cur_cols - 1 : pix_col - HALF;
      for (int r = pix_row - HALF; r <= r_hi; r++) begin
        if (r < 0) continue;
        for (int c = pix_col - HALF; c <= c_hi; c++) begin
          if (c < 0) continue;
          for (int k = 0; k < cur_filters; k++) begin
            a.fil = FSEL_W'(k);
            a.row = POS_W'(r);
            a.col = POS_W'(c);
            a.act = sigmoid_of(conv_sum(k, r, c));
            a.last = 1'b0;
            a.fend = 1'b0;
            pending_acts.push_back(a);
            n++;
          end
        end
      end
      if (n > 0) begin
        pending_acts[$].last = 1'b1;
        pending_acts[$].fend = fdone;
      end
      pix_col++;
      if (pix_col >= cur_cols) begin
        pix_col = 0;
        pix_row++;
        if (pix_row >= cur_rows) pix_row = 0;
      end
    end
  endfunction

  // Sender gap: mostly none, sometimes short, rarely long.
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item at a falling edge and waits until it is accepted.
  task automatic send_item(stim_row_t it);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i <= it.kind;
    filter_sel_i <= it.fsel;
    row_sel_i <= it.rsel;
    col_sel_i <= it.csel;
    value_i <= it.val;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_acts(it);
    if (it.typed && pending_acts.size() > 0 && pending_acts[$].act !== it.typed_act) begin
      n_errors++;
      $display("directed activation: expected %0d, model gives %0d",
               it.typed_act, pending_acts[$].act);
    end
    @(negedge clk_i);
  endtask

  // Waits until the layer is idle, then writes one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    in_valid_i <= 1'b0;
    while (pending_acts.size() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(data);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FILTERS: begin
        cur_filters = clamp_reg(data, 1, NFIL);
      end
      CFG_ROWS: begin
        cur_rows = clamp_reg(data, MIN_SIZE, MROWS);
        pix_row = 0;
        pix_col = 0;
      end
      CFG_COLS: begin
        cur_cols = clamp_reg(data, MIN_SIZE, MCOLS);
        pix_row = 0;
        pix_col = 0;
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic stim_row_t mk(logic [KIND_W-1:0] k, int f, int r, int c, int v);
    stim_row_t it;
    it.kind = k;
    it.fsel = FSEL_W'(f);
    it.rsel = POS_W'(r);
    it.csel = POS_W'(c);
    it.val = 16'(v);
    it.typed = 0;
    it.typed_act = '0;
    return it;
  endfunction

  // Sample values: mostly small so sums stay inside the sigmoid range.
  function automatic int rand_value();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 65535));
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  // Loads every bias that the coming frame may read and that was never loaded.
  task automatic load_biases(int nf, int nr, int nc);
    for (int f = 0; f < nf; f++)
      for (int r = 0; r < nr; r++)
        for (int c = 0; c < nc; c++)
          if (!bias_set[f][r][c]) send_item(mk(KIND_BIAS, f, r, c, rand_value()));
  endtask

  // Occasional item that changes no output or reloads a coefficient.
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_item(mk(KIND_NONE, $urandom_range(0, 7), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 65535)));
      1: send_item(mk(KIND_WEIGHT, $urandom_range(5, 7), $urandom_range(0, 31),
                      $urandom_range(5, 31), $urandom_range(0, 65535)));
      2: send_item(mk(KIND_WEIGHT, $urandom_range(0, 4), $urandom_range(0, 4),
                      $urandom_range(0, 4), rand_value()));
      default: send_item(mk(KIND_BIAS, $urandom_range(0, 7), $urandom_range(0, 31),
                            $urandom_range(0, 31), rand_value()));
    endcase
  endtask

  // One frame phase: configure, cover the biases, then stream pixels with noise.
  // With hold set, the receiver holds off for a long stretch once the pixels start.
  task automatic run_frame(int nf, int nr, int nc, int npix, bit hold);
    int rows_used;
    write_reg(CFG_FILTERS, nf);
    write_reg(CFG_ROWS, nr);
    write_reg(CFG_COLS, nc);
    rows_used = (npix + cur_cols - 1) / cur_cols;
    if (rows_used > cur_rows) rows_used = cur_rows;
    load_biases(cur_filters, rows_used, cur_cols);
    if (hold) hold_req = 1;
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      send_item(mk(KIND_PIXEL, 0, $urandom_range(0, 31), $urandom_range(0, 31),
                   rand_value()));
    end
  endtask

  // Receiver: random stalls, quiet stretches, and one long hold-off on request.
  initial begin
    int n;
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 0;
      end else begin
        n = pick_gap(rx_quiet);
        if (n > 0) begin
          out_ready_i <= 1'b0;
          repeat (n) @(negedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    act_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_acts.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result: filter %0d row %0d col %0d",
                                     filter_out_o, out_row_o, out_col_o);
      end else begin
        want = pending_acts.pop_front();
        if (filter_out_o !== want.fil || out_row_o !== want.row ||
            out_col_o !== want.col || activation_o !== want.act ||
            last_o !== want.last || frame_end_o !== want.fend) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("mismatch: expected f%0d r%0d c%0d act %0d last %0b end %0b",
                     want.fil, want.row, want.col, want.act, want.last, want.fend);
            $display("          got      f%0d r%0d c%0d act %0d last %0b end %0b",
                     filter_out_o, out_row_o, out_col_o, activation_o, last_o,
                     frame_end_o);
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin
    stim_row_t dir_rows[$];
    build_sig_tab();
    cur_filters = RST_FILTERS;
    cur_rows = RST_ROWS;
    cur_cols = RST_COLS;
    pix_row = 0;
    pix_col = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Known coefficients: filter 0 weights zero, its biases zero over a 5 by 5 image.
    tx_quiet = 1;
    for (int k = 0; k < TAPS; k++)
      for (int l = 0; l < TAPS; l++) send_item(mk(KIND_WEIGHT, 0, k, l, 0));
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++) send_item(mk(KIND_BIAS, 0, r, c, 0));
    tx_quiet = 0;

    write_reg(CFG_FILTERS, 1);
    write_reg(CFG_ROWS, 5);
    write_reg(CFG_COLS, 5);

    // Directed part: extreme loads, ignored loads, and the first pixels of a 5x5 frame.
    dir_rows.push_back(mk(KIND_WEIGHT, 0, 2, 2, 32767));
    dir_rows.push_back(mk(KIND_WEIGHT, 0, 0, 0, -32768));
    dir_rows.push_back(mk(KIND_WEIGHT, 7, 0, 0, 1234));
    dir_rows.push_back(mk(KIND_WEIGHT, 0, 5, 0, 999));
    dir_rows.push_back(mk(KIND_WEIGHT, 0, 0, 31, 999));
    dir_rows.push_back(mk(KIND_NONE, 7, 31, 31, 16'hFFFF));
    dir_rows.push_back(mk(KIND_BIAS, 0, 0, 0, 32767));
    dir_rows.push_back(mk(KIND_BIAS, 0, 31, 31, -32768));
    dir_rows.push_back(mk(KIND_BIAS, 6, 3, 3, 555));
    dir_rows.push_back(mk(KIND_PIXEL, 0, 0, 0, 32767));
    dir_rows.push_back(mk(KIND_PIXEL, 0, 0, 0, -32768));
    for (int i = 0; i < 12; i++) dir_rows.push_back(mk(KIND_PIXEL, 0, 0, 0, rand_value()));
    // Pixel (2,2) releases position (0,0): strongly positive, so the output saturates high.
    dir_rows[dir_rows.size() - 2].typed = 1;
    dir_rows[dir_rows.size() - 2].typed_act = 16'hFFFF;
    // Pixel (2,3) releases position (0,1): strongly negative, so the output is zero.
    dir_rows[dir_rows.size() - 1].typed = 1;
    dir_rows[dir_rows.size() - 1].typed_act = 16'h0000;
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // Random weights for the two filters in use from here on.
    for (int f = 0; f < 2; f++)
      for (int k = 0; k < TAPS; k++)
        for (int l = 0; l < TAPS; l++) send_item(mk(KIND_WEIGHT, f, k, l, rand_value()));

    // Full frame with two filters and a long receiver hold-off while pixels keep coming.
    run_frame(2, 5, 5, 25, 1);
    // Saturated register writes: one filter, tallest image, narrowest image.
    rx_quiet = 1;
    run_frame(0, 63, 0, 15, 0);
    rx_quiet = 0;

    in_valid_i <= 1'b0;
    while (pending_acts.size() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (n_errors == 0 && pending_acts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/c2s_pkg.sv
rtl/core/c2s_ram.sv
rtl/core/conv2d_sigmoid_layer.sv
verif/testbench.sv
